// ===== hdl/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

  // Store depth and derived widths
  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // Command kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Result source select
  localparam logic [1:0] EMIT_HEAD  = 2'd0;
  localparam logic [1:0] EMIT_DUMP  = 2'd1;
  localparam logic [1:0] EMIT_EMPTY = 2'd2;
  localparam logic [1:0] EMIT_FULL  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       cap;       // capture input transaction payload
    logic       ins;       // compare-and-shift insert
    logic       pop;       // shift store towards the head
    logic       emit;      // load output register
    logic [1:0] emit_sel;  // result source
  } spq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic             empty;
    logic             full;
    logic             slot_free;
    logic             dump_last;
    logic [CNT_W-1:0] cnt;
  } spq_sts_t;

endpackage

// ===== hdl/spq_datapath.sv =====
// ---------------------------------------------------------------------------
// spq_datapath
// Row of entry cells with parallel compare-and-shift insert, head pop, dump
// read pointer and the registered result stage.
// ---------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  spq_cmd_t           cmd,
  output spq_sts_t           sts,
  input  logic signed [31:0] in_entry_id,
  input  logic signed [31:0] in_entry_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_id,
  output logic signed [31:0] out_priority,
  output logic [1:0]         out_status,
  output logic               out_last
);

  // Entry cells (payload, no reset)
  logic signed [31:0] id_r   [CAPACITY];
  logic signed [31:0] prio_r [CAPACITY];
  logic signed [31:0] id_nxt   [CAPACITY];
  logic signed [31:0] prio_nxt [CAPACITY];
  logic signed [31:0] new_id_r, new_prio_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic               out_valid_r;
  logic signed [31:0] out_id_r, out_prio_r;
  logic [1:0]         out_status_r;
  logic               out_last_r;

  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] prev_ge;
  logic                dump_last;
  logic                slot_free;

  // Each cell compares its own priority against the new one
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (prio_r[i] >= new_prio_r);
    end
    prev_ge = {ge[CAPACITY-2:0], 1'b1};
  end

  // Cell next values: keep, take new entry, or shift from a neighbour
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      id_nxt[i]   = id_r[i];
      prio_nxt[i] = prio_r[i];
    end
    if (cmd.ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!ge[i]) begin
          if (prev_ge[i] || (i == 0)) begin
            id_nxt[i]   = new_id_r;
            prio_nxt[i] = new_prio_r;
          end else begin
            id_nxt[i]   = id_r[(i == 0) ? 0 : i - 1];
            prio_nxt[i] = prio_r[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        id_nxt[i]   = id_r[i+1];
        prio_nxt[i] = prio_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      id_r[i]   <= id_nxt[i];
      prio_r[i] <= prio_nxt[i];
    end
    if (cmd.cap) begin
      new_id_r   <= in_entry_id;
      new_prio_r <= in_entry_priority;
    end
  end

  // Fill count and dump pointer
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.cap) begin
      idx_nxt = '0;
    end else if (cmd.emit && (cmd.emit_sel == EMIT_DUMP)) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign dump_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign slot_free = !out_valid_r || out_ready;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        EMIT_HEAD: begin
          out_id_r     <= id_r[0];
          out_prio_r   <= prio_r[0];
          out_status_r <= ST_OK;
          out_last_r   <= 1'b1;
        end
        EMIT_DUMP: begin
          out_id_r     <= id_r[idx_r];
          out_prio_r   <= prio_r[idx_r];
          out_status_r <= ST_OK;
          out_last_r   <= dump_last;
        end
        EMIT_EMPTY: begin
          out_id_r     <= '0;
          out_prio_r   <= '0;
          out_status_r <= ST_EMPTY;
          out_last_r   <= 1'b1;
        end
        default: begin
          out_id_r     <= '0;
          out_prio_r   <= '0;
          out_status_r <= ST_FULL;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == CNT_W'(CAPACITY));
  assign sts.slot_free = slot_free;
  assign sts.dump_last = dump_last;
  assign sts.cnt       = count_r;

  assign out_valid    = out_valid_r;
  assign out_id       = out_id_r;
  assign out_priority = out_prio_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

endmodule

// ===== hdl/spq_ctrl.sv =====
// ---------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: decodes each input transaction and steps the datapath
// through insert, pop, dump and status results.
// ---------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  spq_sts_t   sts,
  output spq_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_DUMP  = 3'd3;
  localparam logic [2:0] S_EMPTY = 3'd4;
  localparam logic [2:0] S_FULL  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.emit_sel = EMIT_HEAD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          case (in_kind)
            KIND_INSERT: state_nxt = sts.full ? S_FULL : S_INS;
            KIND_POP:    state_nxt = sts.empty ? S_EMPTY : S_POP;
            KIND_DUMP:   state_nxt = sts.empty ? S_IDLE : S_DUMP;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_POP: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.pop   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        cmd.emit_sel = EMIT_DUMP;
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        cmd.emit_sel = EMIT_EMPTY;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FULL: begin
        cmd.emit_sel = EMIT_FULL;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/sorted_priority_queue_top.sv =====
// ---------------------------------------------------------------------------
// sorted_priority_queue_top
// Sorted priority queue: entries kept in descending priority order, oldest
// first among equals, with insert, pop-highest and dump commands.
// ---------------------------------------------------------------------------
//  Channel | Ports                                           | Direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid/in_ready, in_kind, in_entry_id,        | in
//          | in_entry_priority                               |
//  result  | out_valid/out_ready, out_id, out_priority,      | out
//          | out_status, out_last                            |
//
//  Insert is a capture, then one parallel compare-and-shift over all cells.
//  Pop and status results are loaded once the result register is free.
//  Dump emits one entry per cycle from the cell row while the result
//  register is free. Reset empties the queue at once; no clearing pass. A
//  stalled result holds the sequencer in its current step until out_ready.
// ---------------------------------------------------------------------------
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_entry_id,
  input  logic signed [31:0] in_entry_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_id,
  output logic signed [31:0] out_priority,
  output logic [1:0]         out_status,
  output logic               out_last
);

  spq_cmd_t cmd;
  spq_sts_t sts;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Cell row and result stage
  spq_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_entry_id       (in_entry_id),
    .in_entry_priority (in_entry_priority),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_id            (out_id),
    .out_priority      (out_priority),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  // Fill count stays within the store
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    sts.cnt <= CNT_W'(CAPACITY))
    else $error("queue count beyond capacity");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.slot_free)
    else $error("result register overwritten");

  // No insert into a full store
  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !sts.full)
    else $error("insert into full store");

  // Pop removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (sts.cnt == $past(sts.cnt) - CNT_W'(1)))
    else $error("pop count mismatch");

endmodule

// ===== verif/sorted_priority_queue_top_tb.sv =====
// ---------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Self-checking bench for the sorted priority queue. A tracker object keeps
// its own copy of the ordered store, predicts the results of every accepted
// command and checks each result transaction against the oldest one due.
// Directed commands cover the empty, tie and unused-kind cases, and
// random fill, drain and mixed phases follow. Both channels idle at random.
// ---------------------------------------------------------------------------
module sorted_priority_queue_top_tb
  import spq_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Kind value that the queue ignores
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 500;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         SETTLE       = 10;

  // Phases of the random part
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  typedef struct {
    logic signed [31:0] rid;
    logic signed [31:0] rprio;
    logic [1:0]         status;
    logic               last_flag;
  } queue_result_t;

  // Ordered store copy and the results still due from the queue
  class queue_tracker;
    logic signed [31:0] held_ids   [CAPACITY];
    logic signed [31:0] held_prios [CAPACITY];
    int                 held_count;
    queue_result_t      due_results[$];
    int unsigned        errors;

    function new();
      held_count = 0;
      errors     = 0;
    endfunction

    function void push_due(logic signed [31:0] id, logic signed [31:0] prio,
                           logic [1:0] st, logic lst);
      queue_result_t r;
      r.rid       = id;
      r.rprio     = prio;
      r.status    = st;
      r.last_flag = lst;
      due_results.push_back(r);
    endfunction

    // Apply one accepted command and queue up what it should produce
    function void note_command(logic [1:0] kind, logic signed [31:0] id,
                               logic signed [31:0] prio);
      int slot;
      int i;
      case (kind)
        KIND_INSERT: begin
          if (held_count >= CAPACITY) begin
            push_due(32'sd0, 32'sd0, ST_FULL, 1'b1);
          end else begin
            // goes behind every entry of greater or equal priority
            slot = 0;
            while (slot < held_count && held_prios[slot] >= prio) slot++;
            for (i = held_count; i > slot; i--) begin
              held_ids[i]   = held_ids[i-1];
              held_prios[i] = held_prios[i-1];
            end
            held_ids[slot]   = id;
            held_prios[slot] = prio;
            held_count++;
          end
        end
        KIND_POP: begin
          if (held_count == 0) begin
            push_due(32'sd0, 32'sd0, ST_EMPTY, 1'b1);
          end else begin
            push_due(held_ids[0], held_prios[0], ST_OK, 1'b1);
            for (i = 1; i < held_count; i++) begin
              held_ids[i-1]   = held_ids[i];
              held_prios[i-1] = held_prios[i];
            end
            held_count--;
          end
        end
        KIND_DUMP: begin
          for (i = 0; i < held_count; i++)
            push_due(held_ids[i], held_prios[i], ST_OK, i == held_count - 1);
        end
        default: ;
      endcase
    endfunction

    // Compare one result transaction with the oldest result due
    function void check_result(logic signed [31:0] id, logic signed [31:0] prio,
                               logic [1:0] st, logic lst);
      queue_result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing due: out_id %0d out_priority %0d out_status %0d",
               id, prio, st);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (id !== want.rid) begin
        $error("out_id: expected %0d, got %0d", want.rid, id);
        errors++;
      end
      if (prio !== want.rprio) begin
        $error("out_priority: expected %0d, got %0d", want.rprio, prio);
        errors++;
      end
      if (st !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (lst !== want.last_flag) begin
        $error("out_last: expected %0d, got %0d", want.last_flag, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind           = KIND_INSERT;
  logic signed [31:0] in_entry_id       = 32'sd0;
  logic signed [31:0] in_entry_priority = 32'sd0;
  logic               out_valid;
  logic               out_ready         = 1'b0;
  logic signed [31:0] out_id;
  logic signed [31:0] out_priority;
  logic [1:0]         out_status;
  logic               out_last;

  queue_tracker tracker = new();
  bit           no_idle = 1'b0;
  int           stall_cycles = 0;

  sorted_priority_queue_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_entry_id       (in_entry_id),
    .in_entry_priority (in_entry_priority),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_id            (out_id),
    .out_priority      (out_priority),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Priorities: extremes, a narrow band for ties, or anything
  function automatic logic signed [31:0] pick_prio();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh7fffffff;
    if (r == 1) return 32'sh80000000;
    if (r < 6)  return $signed($urandom_range(0, 7)) - 4;
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_kind(phase_t ph);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 75) return KIND_INSERT;
        if (r < 85) return KIND_POP;
      end
      PH_DRAIN: begin
        if (r < 15) return KIND_INSERT;
        if (r < 80) return KIND_POP;
      end
      default: begin
        if (r < 45) return KIND_INSERT;
        if (r < 80) return KIND_POP;
      end
    endcase
    if (r < 95) return KIND_DUMP;
    return KIND_UNUSED;
  endfunction

  // Present one command and hold it until the transaction completes
  task automatic send_command(input logic [1:0] kind, input logic signed [31:0] id,
                              input logic signed [31:0] prio);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_entry_id       <= id;
    in_entry_priority <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every due result has arrived
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  // Result side back-pressure
  initial begin
    int unsigned gap;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Transaction monitors feeding the tracker
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      tracker.note_command(in_kind, in_entry_id, in_entry_priority);
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_id, out_priority, out_status, out_last);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int     sent;
    int     len;
    int     j;
    phase_t ph;
    logic [1:0] kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, ignored kind, extremes and ties
    send_command(KIND_POP,    $urandom, $urandom);
    send_command(KIND_DUMP,   $urandom, $urandom);
    send_command(KIND_UNUSED, 32'sh7fffffff, 32'sh7fffffff);
    send_command(KIND_INSERT, 32'sh7fffffff, 32'sd0);
    send_command(KIND_INSERT, 32'sh80000000, 32'sd0);
    send_command(KIND_INSERT, 32'sd0,        32'sh7fffffff);
    send_command(KIND_INSERT, -32'sd1,       32'sh80000000);
    send_command(KIND_INSERT, 32'sd5,        -32'sd1);
    send_command(KIND_INSERT, 32'sd6,        32'sd1);
    send_command(KIND_UNUSED, -32'sd1,       -32'sd1);
    send_command(KIND_DUMP,   $urandom, $urandom);
    send_command(KIND_POP,    $urandom, $urandom);
    send_command(KIND_POP,    $urandom, $urandom);
    send_command(KIND_INSERT, 32'sd7,        32'sd0);
    send_command(KIND_INSERT, 32'sd8,        32'sh80000000);
    send_command(KIND_DUMP,   $urandom, $urandom);
    repeat (6) send_command(KIND_POP, $urandom, $urandom);
    send_command(KIND_POP,    $urandom, $urandom);
    send_command(KIND_DUMP,   $urandom, $urandom);

    // hold off until the queue has delivered everything
    wait_for_drain();

    // random phases; the first one is a fill phase
    sent = 0;
    ph   = PH_FILL;
    len  = 50;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      for (j = 0; j < len; j++) begin
        kind = pick_kind(ph);
        if (kind == KIND_INSERT)
          send_command(kind, $urandom, pick_prio());
        else
          send_command(kind, $urandom, $urandom);
        if (kind != KIND_UNUSED) sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_for_drain();
      ph  = phase_t'($urandom_range(0, 2));
      len = $urandom_range(20, 80);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (tracker.errors == 0 && tracker.due_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
